// ===== rtl/gmc_pkg.sv =====
// Shared types, codes and helpers for the gate motion controller.
`timescale 1ns / 1ps

package gmc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 24;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PWM_INC        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_FULL       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_TIMEOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_HOLD     = 3'd4;

	// Register reset values
	localparam logic [11:0] RST_PWM_INC        = 12'd120;
	localparam logic [11:0] RST_PWM_FULL       = 12'd4095;
	localparam logic [15:0] RST_RAMP_INTERVAL  = 16'd20;
	localparam logic [23:0] RST_MOTION_TIMEOUT = 24'd70000;
	localparam logic [23:0] RST_ERROR_HOLD     = 24'd2500;

	// Command codes
	localparam logic [1:0] CMD_IDLE    = 2'd0;
	localparam logic [1:0] CMD_GO_OPEN = 2'd1;
	localparam logic [1:0] CMD_GO_SHUT = 2'd2;
	localparam logic [1:0] CMD_TOGGLE  = 2'd3;

	// Drive direction codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_BACK = 2'd2;

	// Gate mode codes as seen on the result
	localparam logic [2:0] MODE_CODE_STOPPED = 3'd0;
	localparam logic [2:0] MODE_CODE_OPENING = 3'd1;
	localparam logic [2:0] MODE_CODE_OPEN    = 3'd2;
	localparam logic [2:0] MODE_CODE_CLOSING = 3'd3;
	localparam logic [2:0] MODE_CODE_CLOSED  = 3'd4;
	localparam logic [2:0] MODE_CODE_ERROR   = 3'd5;

	typedef enum logic [5:0] {
		M_STOPPED = 6'b000001,
		M_OPENING = 6'b000010,
		M_OPEN    = 6'b000100,
		M_CLOSING = 6'b001000,
		M_CLOSED  = 6'b010000,
		M_ERROR   = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [11:0] pwm_inc;
		logic [11:0] pwm_full;
		logic [15:0] ramp_interval;
		logic [23:0] motion_timeout;
		logic [23:0] error_hold;
	} cfg_t;

	typedef struct packed {
		logic [1:0] command;
		logic       open_limit_a;
		logic       open_limit_b;
		logic       close_limit_a;
		logic       close_limit_b;
		logic       trip_a;
		logic       trip_b;
	} tick_t;

	typedef struct packed {
		logic        busy_res;
		logic [2:0]  gate_mode;
		logic [1:0]  drive_direction;
		logic [11:0] enable_pwm;
	} result_t;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			M_STOPPED: c = MODE_CODE_STOPPED;
			M_OPENING: c = MODE_CODE_OPENING;
			M_OPEN:    c = MODE_CODE_OPEN;
			M_CLOSING: c = MODE_CODE_CLOSING;
			M_CLOSED:  c = MODE_CODE_CLOSED;
			M_ERROR:   c = MODE_CODE_ERROR;
			default:   c = MODE_CODE_STOPPED;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/gmc_cfg.sv =====
// Configuration register file of the gate motion controller.
`timescale 1ns / 1ps

module gmc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [gmc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [gmc_pkg::CFG_DATA_W-1:0]    wr_data,
	output gmc_pkg::cfg_t                     cfg
);

	gmc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_inc        <= gmc_pkg::RST_PWM_INC;
			cfg_q.pwm_full       <= gmc_pkg::RST_PWM_FULL;
			cfg_q.ramp_interval  <= gmc_pkg::RST_RAMP_INTERVAL;
			cfg_q.motion_timeout <= gmc_pkg::RST_MOTION_TIMEOUT;
			cfg_q.error_hold     <= gmc_pkg::RST_ERROR_HOLD;
		end else if (wr_en) begin
			// indexes past the list are dropped
			unique case (wr_index)
				gmc_pkg::REG_PWM_INC:        cfg_q.pwm_inc        <= wr_data[11:0];
				gmc_pkg::REG_PWM_FULL:       cfg_q.pwm_full       <= wr_data[11:0];
				gmc_pkg::REG_RAMP_INTERVAL:  cfg_q.ramp_interval  <= wr_data[15:0];
				gmc_pkg::REG_MOTION_TIMEOUT: cfg_q.motion_timeout <= wr_data[23:0];
				gmc_pkg::REG_ERROR_HOLD:     cfg_q.error_hold     <= wr_data[23:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/gmc_core.sv =====
// Per-tick gate state update: mode, shared PWM ramp, direction and timers.
`timescale 1ns / 1ps

module gmc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  gmc_pkg::tick_t     tick,
	input  gmc_pkg::cfg_t      cfg,
	output gmc_pkg::result_t   result
);

	gmc_pkg::mode_t mode_q, mode_d;
	logic [11:0]    level_q, level_d;
	logic           running_q, running_d;
	logic           rising_q, rising_d;
	logic [15:0]    ramp_timer_q, ramp_timer_d;
	logic [23:0]    motion_timer_q, motion_timer_d;
	logic [23:0]    error_timer_q, error_timer_d;
	logic [1:0]     dir_q, dir_d;

	logic           open_both, close_both, trip, at_end, start_ok, busy;
	logic [1:0]     cmd;
	logic [12:0]    level_sum;
	gmc_pkg::mode_t new_mode, end_mode;
	logic [1:0]     new_dir;
	logic           both_end;

	always_comb begin
		open_both  = tick.open_limit_a & tick.open_limit_b;
		close_both = tick.close_limit_a & tick.close_limit_b;
		trip       = tick.trip_a | tick.trip_b;

		mode_d    = mode_q;
		level_d   = level_q;
		running_d = running_q;
		rising_d  = rising_q;
		dir_d     = dir_q;

		// saturating tick counters
		ramp_timer_d   = (ramp_timer_q == '1) ? ramp_timer_q : ramp_timer_q + 16'd1;
		motion_timer_d = (motion_timer_q == '1) ? motion_timer_q : motion_timer_q + 24'd1;
		error_timer_d  = (error_timer_q == '1) ? error_timer_q : error_timer_q + 24'd1;

		if (mode_d == gmc_pkg::M_ERROR && error_timer_d >= cfg.error_hold)
			mode_d = gmc_pkg::M_STOPPED;

		cmd = tick.command;
		if (cmd == gmc_pkg::CMD_TOGGLE) begin
			if (mode_d == gmc_pkg::M_ERROR)
				cmd = gmc_pkg::CMD_IDLE;
			else if (mode_d == gmc_pkg::M_OPEN || mode_d == gmc_pkg::M_OPENING)
				cmd = gmc_pkg::CMD_GO_SHUT;
			else
				cmd = gmc_pkg::CMD_GO_OPEN;
		end

		// opposite request while moving is dropped, never reversed
		start_ok = 1'b0;
		new_mode = gmc_pkg::M_OPENING;
		end_mode = gmc_pkg::M_OPEN;
		new_dir  = gmc_pkg::DIR_FWD;
		both_end = open_both;
		if (cmd == gmc_pkg::CMD_GO_OPEN) begin
			start_ok = (mode_d != gmc_pkg::M_CLOSING);
		end else if (cmd == gmc_pkg::CMD_GO_SHUT) begin
			start_ok = (mode_d != gmc_pkg::M_OPENING);
			new_mode = gmc_pkg::M_CLOSING;
			end_mode = gmc_pkg::M_CLOSED;
			new_dir  = gmc_pkg::DIR_BACK;
			both_end = close_both;
		end
		if (start_ok && mode_d != gmc_pkg::M_ERROR && mode_d != new_mode
				&& mode_d != end_mode) begin
			if (both_end) begin
				mode_d = end_mode;
			end else begin
				dir_d          = new_dir;
				running_d      = 1'b1;
				rising_d       = 1'b1;
				level_d        = 12'd0;
				ramp_timer_d   = 16'd0;
				mode_d         = new_mode;
				motion_timer_d = 24'd0;
			end
		end

		level_sum = {1'b0, level_d} + {1'b0, cfg.pwm_inc};
		if (running_d && ramp_timer_d >= cfg.ramp_interval) begin
			ramp_timer_d = 16'd0;
			if (rising_d) begin
				if (level_sum >= {1'b0, cfg.pwm_full}) begin
					level_d   = cfg.pwm_full;
					running_d = 1'b0;
				end else begin
					level_d = level_sum[11:0];
				end
			end else if (level_d <= cfg.pwm_inc) begin
				level_d   = 12'd0;
				running_d = 1'b0;
			end else begin
				level_d = level_d - cfg.pwm_inc;
			end
		end

		if (mode_d == gmc_pkg::M_OPENING || mode_d == gmc_pkg::M_CLOSING) begin
			at_end = (mode_d == gmc_pkg::M_OPENING) ? open_both : close_both;
			if (trip || (!at_end && motion_timer_d > cfg.motion_timeout)) begin
				running_d     = 1'b1;
				rising_d      = 1'b0;
				ramp_timer_d  = 16'd0;
				mode_d        = gmc_pkg::M_ERROR;
				error_timer_d = 24'd0;
			end else if (at_end) begin
				running_d    = 1'b1;
				rising_d     = 1'b0;
				ramp_timer_d = 16'd0;
				mode_d = (mode_d == gmc_pkg::M_OPENING) ? gmc_pkg::M_OPEN : gmc_pkg::M_CLOSED;
			end
		end else begin
			at_end = 1'b0;
		end

		if ((mode_d == gmc_pkg::M_OPEN || mode_d == gmc_pkg::M_CLOSED
				|| mode_d == gmc_pkg::M_ERROR) && level_d == 12'd0)
			dir_d = gmc_pkg::DIR_STOP;

		// a trip while idle aborts on every tick
		busy = (mode_d == gmc_pkg::M_OPENING || mode_d == gmc_pkg::M_CLOSING);
		if (!busy && trip) begin
			running_d     = 1'b1;
			rising_d      = 1'b0;
			ramp_timer_d  = 16'd0;
			mode_d        = gmc_pkg::M_ERROR;
			error_timer_d = 24'd0;
		end

		result.enable_pwm      = level_d;
		result.drive_direction = dir_d;
		result.gate_mode       = gmc_pkg::mode_code(mode_d);
		result.busy_res        = busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= gmc_pkg::M_STOPPED;
			level_q        <= 12'd0;
			running_q      <= 1'b0;
			rising_q       <= 1'b1;
			ramp_timer_q   <= 16'd0;
			motion_timer_q <= 24'd0;
			error_timer_q  <= 24'd0;
			dir_q          <= gmc_pkg::DIR_STOP;
		end else if (step) begin
			mode_q         <= mode_d;
			level_q        <= level_d;
			running_q      <= running_d;
			rising_q       <= rising_d;
			ramp_timer_q   <= ramp_timer_d;
			motion_timer_q <= motion_timer_d;
			error_timer_q  <= error_timer_d;
			dir_q          <= dir_d;
		end
	end

	// no reversal: a running motion never turns straight into the opposite one
	a_no_rev_open: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q == gmc_pkg::M_OPENING |=> mode_q != gmc_pkg::M_CLOSING)
		else $error("opening reversed into closing");

	a_no_rev_close: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q == gmc_pkg::M_CLOSING |=> mode_q != gmc_pkg::M_OPENING)
		else $error("closing reversed into opening");

	a_start_dir: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode_q != gmc_pkg::M_OPENING && mode_d == gmc_pkg::M_OPENING
		|=> dir_q == gmc_pkg::DIR_FWD && motion_timer_q == 24'd0)
		else $error("opening started without forward drive");

	// an idle trip can enter error with the drive still set, so only the end modes count
	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		step && (mode_d == gmc_pkg::M_OPEN || mode_d == gmc_pkg::M_CLOSED)
		&& level_d == 12'd0 |=> dir_q == gmc_pkg::DIR_STOP)
		else $error("drive left on at an end with zero ramp");

endmodule

// ===== rtl/gate_motion_controller.sv =====
// Top level of the gate motion controller: stream ports, input and result registers.
`timescale 1ns / 1ps

// Two-actuator gate controller. Each request on the slave stream is one
// millisecond tick (command, end switches, overcurrent trips) and yields
// exactly one result (PWM level, drive direction, gate mode, busy) on the
// master stream. A tick is taken into an input register; its full state update
// runs combinationally into the result register, so one tick per clock is
// sustained unless m_axis_tready stalls. The user must write registers through
// the wr_en/wr_index/wr_data port while no tick is in flight; the block does not check.

module gate_motion_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [1:0] command, [2] open_limit_a, [3] open_limit_b, [4] close_limit_a,
	// [5] close_limit_b, [6] trip_a, [7] trip_b
	input  logic [gmc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [11:0] enable_pwm, [13:12] drive_direction, [16:14] gate_mode,
	// [17] busy_res, [23:18] zero
	output logic [gmc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                               wr_en,
	input  logic [gmc_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [gmc_pkg::CFG_DATA_W-1:0]     wr_data
);

	gmc_pkg::cfg_t    cfg;
	gmc_pkg::tick_t   tick_s1;
	logic             valid_s1;
	gmc_pkg::result_t result;
	gmc_pkg::result_t result_s2;
	logic             valid_s2;
	logic             adv_s1;

	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (!valid_s2 || m_axis_tready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tick_s1.command       <= s_axis_tdata[1:0];
			tick_s1.open_limit_a  <= s_axis_tdata[2];
			tick_s1.open_limit_b  <= s_axis_tdata[3];
			tick_s1.close_limit_a <= s_axis_tdata[4];
			tick_s1.close_limit_b <= s_axis_tdata[5];
			tick_s1.trip_a        <= s_axis_tdata[6];
			tick_s1.trip_b        <= s_axis_tdata[7];
		end
		if (adv_s1)
			result_s2 <= result;
	end

	gmc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	gmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.tick   (tick_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, result_s2.busy_res, result_s2.gate_mode,
		result_s2.drive_direction, result_s2.enable_pwm};

endmodule
